// File: src/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, register offsets and constants of the system controller block
// ----------------------------------------------------------------------------
package scr_pkg;

  // command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // decoded register select
  typedef enum logic [3:0] {
    SEL_ID,
    SEL_ZERO,
    SEL_LED,
    SEL_OSC,
    SEL_LOCK,
    SEL_SLOW,
    SEL_FLAG_SET,
    SEL_FLAG_CLR,
    SEL_COLOUR,
    SEL_FAST,
    SEL_PROC,
    SEL_MEM,
    SEL_PERIPH,
    SEL_NONE
  } reg_sel_e;

  // register offsets
  localparam logic [11:0] ADDR_ID          = 12'h000;
  localparam logic [11:0] ADDR_ZERO        = 12'h004;
  localparam logic [11:0] ADDR_LED         = 12'h008;
  localparam logic [11:0] ADDR_OSC_LO      = 12'h00C;
  localparam logic [11:0] ADDR_OSC_HI      = 12'h01C;
  localparam logic [11:0] ADDR_LOCK        = 12'h020;
  localparam logic [11:0] ADDR_SLOW        = 12'h024;
  localparam logic [11:0] ADDR_FLAG_SET    = 12'h030;
  localparam logic [11:0] ADDR_FLAG_CLR    = 12'h034;
  localparam logic [11:0] ADDR_COLOUR      = 12'h050;
  localparam logic [11:0] ADDR_FAST        = 12'h05C;
  localparam logic [11:0] ADDR_PROC        = 12'h084;
  localparam logic [11:0] ADDR_MEM         = 12'h088;
  localparam logic [11:0] ADDR_PERIPH_BASE = 12'hFE0;

  // fixed values
  localparam logic [31:0] SYS_ID        = 32'h0178_0500;
  localparam logic [31:0] PROC_ID       = 32'h0C00_0000;
  localparam logic [31:0] MEM_ID        = 32'hFF00_0000;
  localparam logic [31:0] LOCK_MAGIC    = 32'h0000_A05F;
  localparam logic [15:0] LOCK_MASK     = 16'h7FFF;
  localparam logic [31:0] COLOUR_KEEP   = 32'h0000_3F00;
  localparam logic [31:0] COLOUR_RESET  = 32'h0000_1F00;

  // counter steps
  localparam logic [3:0]  TENTH_LAST    = 4'd9;
  localparam logic [31:0] FAST_MS_STEP  = 32'd24000;
  localparam logic [9:0]  INSTR_STEP    = 10'd24;
  localparam logic [9:0]  INSTR_DIV     = 10'd500;

  // peripheral and cell id bytes at 0xfe0..0xffc
  typedef logic [7:0] periph_id_t [8];
  localparam periph_id_t PERIPH_ID = '{
    8'h11, 8'h10, 8'h04, 8'h00, 8'h0D, 8'hF0, 8'h05, 8'hB1
  };

  typedef struct packed {
    reg_sel_e   sel;
    logic [2:0] id_idx;
  } decode_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
  } result_t;

endpackage

// File: src/scr_if.sv
// ----------------------------------------------------------------------------
// scr_if
// Valid/ready channels of the system controller block
// ----------------------------------------------------------------------------
interface scr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] address;
  logic [31:0] write_data;

  modport source (output valid, output cmd, output address, output write_data,
                  input ready);
  modport sink (input valid, input cmd, input address, input write_data,
                output ready);
endinterface

interface scr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        access_ok;

  modport source (output valid, output read_data, output access_ok, input ready);
  modport sink (input valid, input read_data, input access_ok, output ready);
endinterface

interface scr_cfg_if;
  logic valid;
  logic ready;
  logic instruction_tick_mode;

  modport source (output valid, output instruction_tick_mode, input ready);
  modport sink (input valid, input instruction_tick_mode, output ready);
endinterface

// File: src/system_controller_registers_core.sv
// ----------------------------------------------------------------------------
// system_controller_registers_core
// Board system controller register block: bus reads, writes and ms ticks
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------
//  in_i     | in  | valid / ready | cmd, address, write_data
//  out_o    | out | valid / ready | read_data, access_ok
//  cfg_i    | in  | valid / ready | instruction_tick_mode
//
//  one transaction per cycle is accepted unless the input register stalls; a
//  read or write result passes the input register, then the result register
//  ticks update the counters when they leave the input register, no result
//  a stalled result register holds only read/write transactions; ticks behind
//  it keep flowing, a read/write behind it waits in the input register
//  reset clears all control and sets the stored words to their reset values
//  cfg_i is always ready and takes effect on the next cycle
//
module system_controller_registers_core import scr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  scr_in_if.sink    in_i,
  scr_out_if.source out_o,
  scr_cfg_if.sink   cfg_i
);

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_cmd_q;
  logic [11:0] s1_addr_q;
  logic [31:0] s1_wdata_q;

  // result register
  logic        out_valid_q, out_valid_d;
  result_t     out_q;

  logic        tick_mode_q;

  logic        in_fire;
  logic        needs_result;
  logic        out_free;
  logic        s1_advance;
  logic        out_load;
  decode_t     dec;
  result_t     result;

  // only reads and writes produce a result
  assign needs_result = (s1_cmd_q == CMD_READ) || (s1_cmd_q == CMD_WRITE);
  assign out_free     = !out_valid_q || out_o.ready;
  assign s1_advance   = s1_valid_q && (!needs_result || out_free);
  assign out_load     = s1_advance && needs_result;

  assign in_i.ready   = !s1_valid_q || s1_advance;
  assign in_fire      = in_i.valid && in_i.ready;

  assign cfg_i.ready  = 1'b1;

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_q.read_data;
  assign out_o.access_ok = out_q.access_ok;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  scr_decode u_decode (
    .address_i (s1_addr_q),
    .dec_o     (dec)
  );

  // state changes when the transaction leaves the input register, so a
  // following transaction sees the updated words
  scr_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_mode_i  (tick_mode_q),
    .fire_i       (s1_advance),
    .cmd_i        (s1_cmd_q),
    .dec_i        (dec),
    .write_data_i (s1_wdata_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tick_mode_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        tick_mode_q <= cfg_i.instruction_tick_mode;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q   <= in_i.cmd;
      s1_addr_q  <= in_i.address;
      s1_wdata_q <= in_i.write_data;
    end
    if (out_load) begin
      out_q <= result;
    end
  end

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_advance |-> !in_i.ready)
    else $error("input accepted while input register is stalled");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result lost after leaving input register");

  a_tick_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && !needs_result |=> out_valid_q == $past(out_valid_q && !out_o.ready))
    else $error("tick or unused command produced a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("pending result overwritten");
`endif

endmodule

// File: src/scr_decode.sv
// ----------------------------------------------------------------------------
// scr_decode
// Address decoder of the register window
// ----------------------------------------------------------------------------
module scr_decode import scr_pkg::*; (
  input  logic [11:0] address_i,
  output decode_t     dec_o
);

  always_comb begin
    dec_o.id_idx = address_i[4:2];
    dec_o.sel    = SEL_NONE;
    // oscillator range takes every byte offset
    priority if (address_i >= ADDR_OSC_LO && address_i <= ADDR_OSC_HI) begin
      dec_o.sel = SEL_OSC;
    end else if (address_i[11:5] == ADDR_PERIPH_BASE[11:5] &&
                 address_i[1:0] == 2'b00) begin
      dec_o.sel = SEL_PERIPH;
    end else begin
      unique case (address_i)
        ADDR_ID:       dec_o.sel = SEL_ID;
        ADDR_ZERO:     dec_o.sel = SEL_ZERO;
        ADDR_LED:      dec_o.sel = SEL_LED;
        ADDR_LOCK:     dec_o.sel = SEL_LOCK;
        ADDR_SLOW:     dec_o.sel = SEL_SLOW;
        ADDR_FLAG_SET: dec_o.sel = SEL_FLAG_SET;
        ADDR_FLAG_CLR: dec_o.sel = SEL_FLAG_CLR;
        ADDR_COLOUR:   dec_o.sel = SEL_COLOUR;
        ADDR_FAST:     dec_o.sel = SEL_FAST;
        ADDR_PROC:     dec_o.sel = SEL_PROC;
        ADDR_MEM:      dec_o.sel = SEL_MEM;
        default:       dec_o.sel = SEL_NONE;
      endcase
    end
  end

endmodule

// File: src/scr_regs.sv
// ----------------------------------------------------------------------------
// scr_regs
// Stored words, tick counters and read/write response logic
// ----------------------------------------------------------------------------
module scr_regs import scr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_mode_i,
  input  logic        fire_i,
  input  logic [1:0]  cmd_i,
  input  decode_t     dec_i,
  input  logic [31:0] write_data_i,
  output result_t     result_o
);

  logic [31:0] led_q, led_d;
  logic [15:0] lock_q, lock_d;
  logic [31:0] flag_q, flag_d;
  logic [31:0] colour_q, colour_d;
  logic [3:0]  tenth_q, tenth_d;
  logic [31:0] slow_q, slow_d;
  logic [31:0] fast_ms_q, fast_ms_d;
  logic [31:0] fast_instr_q, fast_instr_d;
  logic [8:0]  rem_q, rem_d;
  logic [9:0]  rem_sum;

  // state update
  always_comb begin
    led_d        = led_q;
    lock_d       = lock_q;
    flag_d       = flag_q;
    colour_d     = colour_q;
    tenth_d      = tenth_q;
    slow_d       = slow_q;
    fast_ms_d    = fast_ms_q;
    fast_instr_d = fast_instr_q;
    rem_d        = rem_q;
    rem_sum      = {1'b0, rem_q} + INSTR_STEP;
    if (fire_i) begin
      unique case (cmd_i)
        CMD_WRITE: begin
          unique case (dec_i.sel)
            SEL_LED: led_d = write_data_i;
            SEL_LOCK: begin
              lock_d = (write_data_i == LOCK_MAGIC) ? LOCK_MAGIC[15:0]
                                                    : (write_data_i[15:0] & LOCK_MASK);
            end
            SEL_FLAG_SET: flag_d = flag_q | write_data_i;
            SEL_FLAG_CLR: flag_d = flag_q & ~write_data_i;
            SEL_COLOUR: begin
              colour_d = (colour_q & COLOUR_KEEP) | (write_data_i & ~COLOUR_KEEP);
            end
            default: ;
          endcase
        end
        CMD_TICK: begin
          if (tenth_q == TENTH_LAST) begin
            tenth_d = '0;
            slow_d  = slow_q + 32'd1;
          end else begin
            tenth_d = tenth_q + 4'd1;
          end
          fast_ms_d = fast_ms_q + FAST_MS_STEP;
          if (rem_sum >= INSTR_DIV) begin
            rem_d        = 9'(rem_sum - INSTR_DIV);
            fast_instr_d = fast_instr_q + 32'd1;
          end else begin
            rem_d = rem_sum[8:0];
          end
        end
        default: ;
      endcase
    end
  end

  // response
  always_comb begin
    result_o.read_data = '0;
    result_o.access_ok = 1'b0;
    if (cmd_i == CMD_READ) begin
      result_o.access_ok = 1'b1;
      unique case (dec_i.sel)
        SEL_ID:     result_o.read_data = SYS_ID;
        SEL_LED:    result_o.read_data = led_q;
        SEL_LOCK:   result_o.read_data = {16'h0000, lock_q};
        SEL_SLOW:   result_o.read_data = slow_q;
        SEL_FLAG_SET: result_o.read_data = flag_q;
        SEL_COLOUR: result_o.read_data = colour_q;
        SEL_FAST:   result_o.read_data = tick_mode_i ? fast_instr_q : fast_ms_q;
        SEL_PROC:   result_o.read_data = PROC_ID;
        SEL_MEM:    result_o.read_data = MEM_ID;
        SEL_PERIPH: result_o.read_data = {24'h000000, PERIPH_ID[dec_i.id_idx]};
        SEL_ZERO, SEL_OSC: result_o.read_data = '0;
        default:    result_o.access_ok = 1'b0;
      endcase
    end else begin
      unique case (dec_i.sel)
        SEL_LED, SEL_OSC, SEL_LOCK, SEL_FLAG_SET, SEL_FLAG_CLR, SEL_COLOUR:
          result_o.access_ok = 1'b1;
        default: result_o.access_ok = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q        <= '0;
      lock_q       <= '0;
      flag_q       <= '0;
      colour_q     <= COLOUR_RESET;
      tenth_q      <= '0;
      slow_q       <= '0;
      fast_ms_q    <= '0;
      fast_instr_q <= '0;
      rem_q        <= '0;
    end else begin
      led_q        <= led_d;
      lock_q       <= lock_d;
      flag_q       <= flag_d;
      colour_q     <= colour_d;
      tenth_q      <= tenth_d;
      slow_q       <= slow_d;
      fast_ms_q    <= fast_ms_d;
      fast_instr_q <= fast_instr_d;
      rem_q        <= rem_d;
    end
  end

`ifndef ASSERT_OFF
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, rem_q} < INSTR_DIV)
    else $error("instruction remainder out of range");

  a_tenth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tenth_q <= TENTH_LAST)
    else $error("tenth prescaler out of range");

  a_colour_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (colour_q & COLOUR_KEEP) == (COLOUR_RESET & COLOUR_KEEP))
    else $error("protected colour bits changed");
`endif

endmodule
